// ===== hdl/binary_to_decimal_digits_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal digit converter
// Clocked property checks shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_DIGITS_ASSERT_SVH
`define BINARY_TO_DECIMAL_DIGITS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define B2DD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define B2DD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/b2dd_pkg.sv =====
// ----------------------------------------------------------------------------
// b2dd_pkg
// Types and constants of the binary to decimal digit converter.
// ----------------------------------------------------------------------------
package b2dd_pkg;

    localparam int VALUE_W          = 64;
    localparam int CHAR_W           = 6;
    localparam int DATA_WIDTH_DEF   = 64;
    localparam int MAX_DIGITS_DEF   = 20;
    localparam int NIBBLE_W         = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic {
        MODE_SIGNED   = 1'b0,
        MODE_UNSIGNED = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

endpackage

// ===== hdl/b2dd_in_if.sv =====
// ----------------------------------------------------------------------------
// b2dd_in_if
// Input channel of the converter: one integer word and its mode per beat.
// ----------------------------------------------------------------------------
interface b2dd_in_if;
    import b2dd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

// ===== hdl/b2dd_out_if.sv =====
// ----------------------------------------------------------------------------
// b2dd_out_if
// Output channel of the converter: one ASCII digit per beat.
// ----------------------------------------------------------------------------
interface b2dd_out_if;
    import b2dd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              negative;
    logic              last_digit;

    modport source (output valid, output digit_char, output negative, output last_digit,
                    input ready);
    modport sink   (input valid, input digit_char, input negative, input last_digit,
                    output ready);
endinterface

// ===== hdl/binary_to_decimal_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_digits
// Converts one integer word to its decimal digits in ASCII, most significant
// first, with no leading zeros.
// ----------------------------------------------------------------------------
// Use: present a word on i_in (value, mode 0 signed / 1 unsigned); only the
// low DATA_WIDTH bits count. The word is taken when valid and ready meet.
// o_out then gives one beat per decimal digit of the magnitude, each with
// the sign flag, and last_digit set on the final beat. Zero gives one '0'.
// Steps: the word is taken in the idle state, then shift-and-add-3 in the
// conversion state builds the BCD register (one input bit a cycle), then
// the skip state drops each leading zero digit (at most MAX_DIGITS-1) and
// settles on the first digit. Digits follow at one beat per cycle while the
// receiver is ready; i_in.ready is high only while no word is in progress.
// A stall on o_out holds the current digit until it is taken.
// Reset (synchronous, active low) returns to idle and drops any word in
// progress.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_digits_assert.svh"

module binary_to_decimal_digits #(
    parameter int DATA_WIDTH = b2dd_pkg::DATA_WIDTH_DEF,
    parameter int MAX_DIGITS = b2dd_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2dd_in_if.sink    i_in,
    b2dd_out_if.source o_out
);
    import b2dd_pkg::*;

    localparam int BCD_W = MAX_DIGITS * NIBBLE_W;
    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    t_state                r_state;
    t_state                n_state;
    logic [DATA_WIDTH-1:0] r_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [CNT_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_neg;

    logic [DATA_WIDTH-1:0] raw;
    logic                  neg_in;
    logic [DATA_WIDTH-1:0] mag_in;
    logic [BCD_W-1:0]      bcd_adj;
    logic [NIBBLE_W-1:0]   top_digit;
    logic                  in_beat;
    logic                  out_beat;

    assign raw       = i_in.value[DATA_WIDTH-1:0];
    assign neg_in    = (t_mode'(i_in.mode) == MODE_SIGNED) && raw[DATA_WIDTH-1];
    assign mag_in    = neg_in ? (~raw + DATA_WIDTH'(1)) : raw;
    assign top_digit = r_bcd[BCD_W-1 -: NIBBLE_W];
    assign in_beat   = i_in.valid && i_in.ready;
    assign out_beat  = o_out.valid && o_out.ready;

    // add 3 to every digit of five or more before the doubling shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*NIBBLE_W +: NIBBLE_W] >= NIBBLE_W'(5)) begin
                bcd_adj[d*NIBBLE_W +: NIBBLE_W] = r_bcd[d*NIBBLE_W +: NIBBLE_W] + NIBBLE_W'(3);
            end else begin
                bcd_adj[d*NIBBLE_W +: NIBBLE_W] = r_bcd[d*NIBBLE_W +: NIBBLE_W];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cnt == '0) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit != '0 || r_idx == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_out.ready && r_idx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready       = (r_state == ST_IDLE);
        o_out.valid      = (r_state == ST_EMIT);
        o_out.digit_char = ASCII_ZERO + CHAR_W'(top_digit);
        o_out.negative   = r_neg;
        o_out.last_digit = (r_idx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    r_mag <= mag_in;
                    r_neg <= neg_in;
                    r_bcd <= '0;
                    r_cnt <= CNT_W'(DATA_WIDTH - 1);
                    r_idx <= IDX_W'(MAX_DIGITS - 1);
                end
            end
            ST_CONV: begin
                // shift the next magnitude bit into the decimal register
                r_bcd <= {bcd_adj[BCD_W-2:0], r_mag[DATA_WIDTH-1]};
                r_mag <= {r_mag[DATA_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            ST_SKIP: begin
                if (top_digit == '0 && r_idx != '0) begin
                    r_bcd <= {r_bcd[BCD_W-NIBBLE_W-1:0], NIBBLE_W'(0)};
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            ST_EMIT: begin
                // advance to the next digit once this beat is taken
                if (out_beat && r_idx != '0) begin
                    r_bcd <= {r_bcd[BCD_W-NIBBLE_W-1:0], NIBBLE_W'(0)};
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    `B2DD_ASSERT(a_digit_decimal, o_out.valid |-> (top_digit <= NIBBLE_W'(9)),
        "output digit is not decimal")
    `B2DD_ASSERT(a_accept_starts_conv, in_beat |=> (r_state == ST_CONV),
        "accepted word did not start conversion")
    `B2DD_ASSERT(a_last_beat_idle, (out_beat && o_out.last_digit) |=> i_in.ready,
        "block not idle after last digit")
    `B2DD_ASSERT(a_no_overlap, !(i_in.ready && o_out.valid),
        "input ready while digits still pending")
    `B2DD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE),
        "reset did not return to idle")

endmodule
